// File: hw/rtl/cttg_pkg.sv
// Shared types, constants and tables for the coordinate text to grid converter.
`timescale 1ns / 1ps
package cttg_pkg;

   localparam int unsigned CTTG_QUEUE_DEPTH = 4;

   localparam logic [30:0] MAG_LIMIT    = 31'h7FFF_FFFF;
   localparam logic [2:0]  FRACTION_END = 3'd7;
   localparam logic [31:0] OFFSET_MICRO = 32'd180000000;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // span 360000000 = 2^9 * 703125, so (s << 32) / span = (s << 23) / 703125
   localparam logic [19:0] SPAN_ODD    = 20'd703125;
   localparam int unsigned RECIP_SHIFT = 28;
   localparam logic [63:0] RECIP_WIDE  = (64'd1 << 51) / 64'd703125;
   localparam logic [31:0] GRID_RECIP  = RECIP_WIDE[31:0];
   localparam int unsigned CORR_SHIFT  = 44;
   localparam logic [63:0] CORR_WIDE   = ((64'd1 << 44) + 64'd703124) / 64'd703125;
   localparam logic [24:0] CORR_RECIP  = CORR_WIDE[24:0];

   typedef struct packed {
      logic [7:0]  text_char;
      logic        start_req;
      logic [31:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [31:0] latitude_grid;
      logic [31:0] longitude_grid;
      logic [31:0] point_index;
      logic        parse_ok;
      logic        overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      NUM_LATITUDE  = 2'd0,
      NUM_PAIR_OK   = 2'd1,
      NUM_PAIR_FAIL = 2'd2
   } num_kind_type;

   typedef struct packed {
      num_kind_type kind;
      logic [30:0]  magnitude;
      logic [2:0]   fraction_count;
      logic         negative;
      logic [31:0]  point_index;
      logic         digit_overflow;
   } num_type;

   function automatic logic [19:0] scale_factor(input logic [2:0] fraction_count);
      logic [19:0] factor;
      unique case (fraction_count) inside
         3'd0, 3'd1: factor = 20'd1000000;
         3'd2:       factor = 20'd100000;
         3'd3:       factor = 20'd10000;
         3'd4:       factor = 20'd1000;
         3'd5:       factor = 20'd100;
         3'd6:       factor = 20'd10;
         default:    factor = 20'd1;
      endcase
      return factor;
   endfunction

endpackage

// File: hw/rtl/coordinate_text_to_grid_top.sv
// Top level of the coordinate text to grid converter.
// Throughput: one character beat per cycle while req_stall is low; one result
//   beat per cycle at most. A result passes the record queue and the scale,
//   sign, offset, estimate, remainder and correction stages before it leaves.
// req_stall rises only while the record queue is full under rsp_stall.
// Reset: synchronous; clears parser state, queue pointers and pipeline valids.
`timescale 1ns / 1ps
module coordinate_text_to_grid_top #(
   parameter int unsigned QUEUE_DEPTH = cttg_pkg::CTTG_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cttg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cttg_pkg::rsp_type rsp_data
);
   import cttg_pkg::*;

   logic    req_fire;
   logic    push_valid;
   num_type push_data;
   logic    queue_full;
   logic    queue_pop;
   logic    queue_valid;
   num_type queue_data;

   assign req_stall = queue_full;
   assign req_fire  = req_valid && !req_stall;

   cttg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   cttg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_data   (queue_data)
   );

   cttg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_data   (queue_data),
      .in_pop    (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/cttg_front.sv
// Character parser: accumulates digits and emits one record per finished number.
`timescale 1ns / 1ps
module cttg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  cttg_pkg::req_type req_data,
   output logic             push_valid,
   output cttg_pkg::num_type push_data
);
   import cttg_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_LAT_FIRST = 5'b00010,
      PH_LAT_BODY  = 5'b00100,
      PH_LON_FIRST = 5'b01000,
      PH_LON_BODY  = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_eff;
   logic        negative_ff, negative_in, negative_eff;
   logic [30:0] acc_ff, acc_in, acc_eff;
   logic [2:0]  frac_ff, frac_in, frac_eff;
   logic        ovf_ff, ovf_in, ovf_eff;
   logic [31:0] index_ff, index_in, index_eff;

   logic        is_first;
   logic        in_latitude;
   logic        is_digit;
   logic        consumed;
   logic        finish;
   logic [7:0]  digit_offset;
   logic [34:0] grown;

   always_comb begin
      phase_eff    = req_data.start_req ? PH_LAT_FIRST : phase_ff;
      negative_eff = req_data.start_req ? 1'b0 : negative_ff;
      acc_eff      = req_data.start_req ? 31'd0 : acc_ff;
      frac_eff     = req_data.start_req ? 3'd0 : frac_ff;
      ovf_eff      = req_data.start_req ? 1'b0 : ovf_ff;
      index_eff    = req_data.start_req ? req_data.entry_index : index_ff;

      is_first     = (phase_eff == PH_LAT_FIRST) || (phase_eff == PH_LON_FIRST);
      in_latitude  = (phase_eff == PH_LAT_FIRST) || (phase_eff == PH_LAT_BODY);
      is_digit     = (req_data.text_char >= CHAR_ZERO) && (req_data.text_char <= CHAR_NINE);
      digit_offset = req_data.text_char - CHAR_ZERO;
      grown        = {4'd0, acc_eff} * 35'd10 + {31'd0, digit_offset[3:0]};

      phase_in    = phase_eff;
      negative_in = negative_eff;
      acc_in      = acc_eff;
      frac_in     = frac_eff;
      ovf_in      = ovf_eff;
      index_in    = index_eff;
      consumed    = 1'b0;
      finish      = 1'b0;

      push_data.kind           = NUM_PAIR_OK;
      push_data.magnitude      = acc_eff;
      push_data.fraction_count = frac_eff;
      push_data.negative       = negative_eff;
      push_data.point_index    = index_eff;
      push_data.digit_overflow = ovf_eff;

      if (phase_eff != PH_IDLE) begin
         if (is_first && (req_data.text_char == CHAR_MINUS)) begin
            negative_in = 1'b1;
            consumed    = 1'b1;
         end else if (req_data.text_char == CHAR_POINT) begin
            if (frac_eff == 3'd0) begin
               frac_in  = 3'd1;
               consumed = 1'b1;
            end
         end else if (is_digit) begin
            consumed = 1'b1;
            if (frac_eff != FRACTION_END) begin
               if (grown > {4'd0, MAG_LIMIT}) begin
                  acc_in = MAG_LIMIT;
                  ovf_in = 1'b1;
               end else begin
                  acc_in = grown[30:0];
               end
               if (frac_eff != 3'd0) begin
                  frac_in = frac_eff + 3'd1;
               end
            end
         end

         if (consumed) begin
            if (phase_eff == PH_LAT_FIRST) begin
               phase_in = PH_LAT_BODY;
            end else if (phase_eff == PH_LON_FIRST) begin
               phase_in = PH_LON_BODY;
            end
         end else begin
            finish      = 1'b1;
            negative_in = 1'b0;
            acc_in      = 31'd0;
            frac_in     = 3'd0;
            if (in_latitude) begin
               if (req_data.text_char == CHAR_SEMI) begin
                  push_data.kind = NUM_LATITUDE;
                  phase_in       = PH_LON_FIRST;
               end else begin
                  push_data.kind = NUM_PAIR_FAIL;
                  phase_in       = PH_IDLE;
               end
            end else begin
               push_data.kind = NUM_PAIR_OK;
               phase_in       = PH_IDLE;
            end
         end
      end
   end

   assign push_valid = req_fire && finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         negative_ff <= 1'b0;
         acc_ff      <= 31'd0;
         frac_ff     <= 3'd0;
         ovf_ff      <= 1'b0;
         index_ff    <= 32'd0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
         frac_ff     <= frac_in;
         ovf_ff      <= ovf_in;
         index_ff    <= index_in;
      end
   end

endmodule

// File: hw/rtl/cttg_queue.sv
// Short record queue between the parser and the grid mapping pipeline.
`timescale 1ns / 1ps
module cttg_queue #(
   parameter int unsigned DEPTH = cttg_pkg::CTTG_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  cttg_pkg::num_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output cttg_pkg::num_type pop_data
);
   import cttg_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   num_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/cttg_back.sv
// Grid mapping pipeline: scale, sign, offset and divide by the span.
`timescale 1ns / 1ps
module cttg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cttg_pkg::num_type in_data,
   output logic             in_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cttg_pkg::rsp_type rsp_data
);
   import cttg_pkg::*;

   logic advance;

   // scale
   logic         s1_valid_ff;
   num_kind_type s1_kind_ff;
   logic [50:0]  s1_product_ff;
   logic         s1_negative_ff;
   logic [31:0]  s1_index_ff;
   logic         s1_dovf_ff;

   // saturate and sign
   logic         saturated;
   logic [30:0]  s1_magnitude;
   logic [31:0]  s1_micro;
   logic         s1_final;
   logic [31:0]  lat_micro_ff;
   logic         lat_ovf_ff;

   logic         s2_valid_ff;
   logic [31:0]  s2_micro_ff;
   logic [31:0]  s2_lat_ff;
   logic         s2_ok_ff;
   logic         s2_ovf_ff;
   logic [31:0]  s2_index_ff;

   // offset
   logic         s3_valid_ff;
   logic [31:0]  s3_lat_ff;
   logic [31:0]  s3_lon_ff;
   logic         s3_ok_ff;
   logic         s3_ovf_ff;
   logic [31:0]  s3_index_ff;

   // reciprocal estimate
   logic [63:0]  lat_estimate;
   logic [63:0]  lon_estimate;
   logic         s4_valid_ff;
   logic [35:0]  s4_lat_q_ff;
   logic [35:0]  s4_lon_q_ff;
   logic         s4_lat_lsb_ff;
   logic         s4_lon_lsb_ff;
   logic         s4_ok_ff;
   logic         s4_ovf_ff;
   logic [31:0]  s4_index_ff;

   // remainder
   logic [43:0]  lat_back;
   logic [43:0]  lon_back;
   logic         s5_valid_ff;
   logic [31:0]  s5_lat_q_ff;
   logic [31:0]  s5_lon_q_ff;
   logic [23:0]  s5_lat_rem_ff;
   logic [23:0]  s5_lon_rem_ff;
   logic         s5_ok_ff;
   logic         s5_ovf_ff;
   logic [31:0]  s5_index_ff;

   // correction
   logic [48:0]  lat_corr_full;
   logic [48:0]  lon_corr_full;
   logic         s6_valid_ff;
   logic [31:0]  s6_lat_q_ff;
   logic [31:0]  s6_lon_q_ff;
   logic [4:0]   s6_lat_corr_ff;
   logic [4:0]   s6_lon_corr_ff;
   logic         s6_ok_ff;
   logic         s6_ovf_ff;
   logic [31:0]  s6_index_ff;

   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;
   rsp_type      rsp_data_in;
   logic [31:0]  lat_grid;
   logic [31:0]  lon_grid;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign in_pop    = advance && in_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      saturated    = (s1_product_ff > {20'd0, MAG_LIMIT});
      s1_magnitude = saturated ? MAG_LIMIT : s1_product_ff[30:0];
      s1_micro     = s1_negative_ff ? 32'd0 - {1'b0, s1_magnitude} : {1'b0, s1_magnitude};
      s1_final     = s1_valid_ff && (s1_kind_ff != NUM_LATITUDE);

      lat_estimate = {32'd0, s3_lat_ff} * {32'd0, GRID_RECIP};
      lon_estimate = {32'd0, s3_lon_ff} * {32'd0, GRID_RECIP};

      lat_back = {20'd0, s4_lat_q_ff[23:0]} * {24'd0, SPAN_ODD};
      lon_back = {20'd0, s4_lon_q_ff[23:0]} * {24'd0, SPAN_ODD};

      lat_corr_full = {25'd0, s5_lat_rem_ff} * {24'd0, CORR_RECIP};
      lon_corr_full = {25'd0, s5_lon_rem_ff} * {24'd0, CORR_RECIP};

      lat_grid = s6_lat_q_ff + {27'd0, s6_lat_corr_ff};
      lon_grid = s6_lon_q_ff + {27'd0, s6_lon_corr_ff};

      rsp_data_in.latitude_grid  = s6_ok_ff ? lat_grid : 32'd0;
      rsp_data_in.longitude_grid = s6_ok_ff ? lon_grid : 32'd0;
      rsp_data_in.point_index    = s6_index_ff;
      rsp_data_in.parse_ok       = s6_ok_ff;
      rsp_data_in.overflow       = s6_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lat_ovf_ff   <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_final;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
         if (s1_valid_ff && (s1_kind_ff == NUM_LATITUDE)) begin
            lat_ovf_ff <= saturated;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff     <= in_data.kind;
         s1_product_ff  <= {20'd0, in_data.magnitude}
                           * {31'd0, scale_factor(in_data.fraction_count)};
         s1_negative_ff <= in_data.negative;
         s1_index_ff    <= in_data.point_index;
         s1_dovf_ff     <= in_data.digit_overflow;

         if (s1_valid_ff && (s1_kind_ff == NUM_LATITUDE)) begin
            lat_micro_ff <= s1_micro;
         end

         s2_micro_ff <= s1_micro;
         s2_lat_ff   <= lat_micro_ff;
         s2_ok_ff    <= (s1_kind_ff == NUM_PAIR_OK);
         s2_ovf_ff   <= s1_dovf_ff || saturated
                        || ((s1_kind_ff == NUM_PAIR_OK) && lat_ovf_ff);
         s2_index_ff <= s1_index_ff;

         s3_lat_ff   <= {s2_lat_ff[30:0], 1'b0} + OFFSET_MICRO;
         s3_lon_ff   <= s2_micro_ff + OFFSET_MICRO;
         s3_ok_ff    <= s2_ok_ff;
         s3_ovf_ff   <= s2_ovf_ff;
         s3_index_ff <= s2_index_ff;

         s4_lat_q_ff   <= lat_estimate[63:RECIP_SHIFT];
         s4_lon_q_ff   <= lon_estimate[63:RECIP_SHIFT];
         s4_lat_lsb_ff <= s3_lat_ff[0];
         s4_lon_lsb_ff <= s3_lon_ff[0];
         s4_ok_ff      <= s3_ok_ff;
         s4_ovf_ff     <= s3_ovf_ff;
         s4_index_ff   <= s3_index_ff;

         s5_lat_q_ff   <= s4_lat_q_ff[31:0];
         s5_lon_q_ff   <= s4_lon_q_ff[31:0];
         s5_lat_rem_ff <= {s4_lat_lsb_ff, 23'd0} - lat_back[23:0];
         s5_lon_rem_ff <= {s4_lon_lsb_ff, 23'd0} - lon_back[23:0];
         s5_ok_ff      <= s4_ok_ff;
         s5_ovf_ff     <= s4_ovf_ff;
         s5_index_ff   <= s4_index_ff;

         s6_lat_q_ff    <= s5_lat_q_ff;
         s6_lon_q_ff    <= s5_lon_q_ff;
         s6_lat_corr_ff <= lat_corr_full[CORR_SHIFT+4:CORR_SHIFT];
         s6_lon_corr_ff <= lon_corr_full[CORR_SHIFT+4:CORR_SHIFT];
         s6_ok_ff       <= s5_ok_ff;
         s6_ovf_ff      <= s5_ovf_ff;
         s6_index_ff    <= s5_index_ff;

         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: hw/rtl/cttg_checker.sv
// Port-level checks for the coordinate text to grid converter, bound to the top level.
`timescale 1ns / 1ps
module cttg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cttg_pkg::rsp_type rsp_data
);
   import cttg_pkg::*;

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs active after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.parse_ok |->
         rsp_data.latitude_grid == 32'd0 && rsp_data.longitude_grid == 32'd0)
      else $error("failed pair carries nonzero grid");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("queue filled without an accepted beat");

endmodule

bind coordinate_text_to_grid_top cttg_checker u_cttg_checker (.*);

// File: sim/coordinate_text_to_grid_top_tb.sv
// Self-checking bench for the coordinate text to grid converter: directed and random pair text.
`timescale 1ns / 1ps
module coordinate_text_to_grid_top_tb;
   import cttg_pkg::*;

   localparam logic [31:0] GRID_OFFSET   = 32'd180000000;
   localparam logic [63:0] GRID_SPAN     = 64'd360000000;
   localparam logic [31:0] MAG_CEILING   = 32'h7FFF_FFFF;
   localparam logic [2:0]  FRACTION_STOP = 3'd7;
   localparam int          CHAR_TARGET   = 1700;

   typedef enum logic [2:0] {
      P_IDLE,
      P_LAT_SIGN,
      P_LAT_DIGITS,
      P_LON_SIGN,
      P_LON_DIGITS
   } parse_phase_type;

   class coord_to_grid;
      parse_phase_type phase;
      bit        negative;
      bit [31:0] magnitude;
      bit [2:0]  frac_digits;
      bit [31:0] lat_micro;
      bit [31:0] pair_index;
      bit        saturated;
      rsp_type   pending_points[$];
      int        bad_fields;

      function new();
         phase = P_IDLE;
         clear_number();
         lat_micro = 0;
         pair_index = 0;
         saturated = 0;
         bad_fields = 0;
      endfunction

      function void clear_number();
         negative = 0;
         magnitude = 0;
         frac_digits = 0;
      endfunction

      function void scale_digit(bit [3:0] digit);
         bit [35:0] t;
         t = {4'd0, magnitude} * 36'd10 + {32'd0, digit};
         if (t > {4'd0, MAG_CEILING}) begin
            magnitude = MAG_CEILING;
            saturated = 1;
         end else begin
            magnitude = t[31:0];
         end
      endfunction

      function bit absorb(bit [7:0] c, bit first);
         if (first && c == CHAR_MINUS) begin
            negative = 1;
            return 1;
         end
         if (c == CHAR_POINT) begin
            if (frac_digits != 0) return 0;
            frac_digits = 1;
            return 1;
         end
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (frac_digits < FRACTION_STOP) begin
               scale_digit(4'(c - CHAR_ZERO));
               if (frac_digits != 0) frac_digits++;
            end
            return 1;
         end
         return 0;
      endfunction

      function bit [31:0] signed_micro();
         bit [2:0] e;
         e = (frac_digits == 0) ? 3'd1 : frac_digits;
         while (e < FRACTION_STOP) begin
            scale_digit(4'd0);
            e++;
         end
         return negative ? 32'd0 - magnitude : magnitude;
      endfunction

      function bit [31:0] to_grid(bit [31:0] micro);
         bit [31:0] shifted;
         bit [63:0] quotient;
         shifted = micro + GRID_OFFSET;
         quotient = {shifted, 32'd0} / GRID_SPAN;
         return quotient[31:0];
      endfunction

      function void take_char(req_type beat);
         bit        first;
         bit [31:0] value;
         rsp_type   point;
         if (beat.start_req) begin
            pair_index = beat.entry_index;
            saturated = 0;
            clear_number();
            phase = P_LAT_SIGN;
         end
         if (phase == P_IDLE) return;
         first = (phase == P_LAT_SIGN || phase == P_LON_SIGN);
         if (absorb(beat.text_char, first)) begin
            if (phase == P_LAT_SIGN) phase = P_LAT_DIGITS;
            else if (phase == P_LON_SIGN) phase = P_LON_DIGITS;
            return;
         end
         value = signed_micro();
         point.point_index = pair_index;
         point.overflow = saturated;
         if (phase == P_LAT_SIGN || phase == P_LAT_DIGITS) begin
            if (beat.text_char == CHAR_SEMI) begin
               lat_micro = value;
               clear_number();
               phase = P_LON_SIGN;
               return;
            end
            point.latitude_grid = 0;
            point.longitude_grid = 0;
            point.parse_ok = 0;
         end else begin
            point.latitude_grid = to_grid(lat_micro << 1);
            point.longitude_grid = to_grid(value);
            point.parse_ok = 1;
         end
         pending_points = {pending_points, point};
         phase = P_IDLE;
         clear_number();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            bad_fields++;
         end
      endfunction

      function void check_point(rsp_type got);
         rsp_type want;
         if (pending_points.size() == 0) begin
            $error("unexpected result beat, point_index %h", got.point_index);
            bad_fields++;
            return;
         end
         want = pending_points.pop_front();
         compare_field("latitude_grid", want.latitude_grid, got.latitude_grid);
         compare_field("longitude_grid", want.longitude_grid, got.longitude_grid);
         compare_field("point_index", want.point_index, got.point_index);
         compare_field("parse_ok", {31'd0, want.parse_ok}, {31'd0, got.parse_ok});
         compare_field("overflow", {31'd0, want.overflow}, {31'd0, got.overflow});
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   coord_to_grid converter;
   int req_idle_pct = 23;
   int rsp_idle_pct = 23;
   int chars_sent = 0;

   coordinate_text_to_grid_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) converter.check_point(rsp_data);
   end

   task automatic send_beat(input req_type beat);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      converter.take_char(beat);
      @(negedge clock);
   endtask

   task automatic send_text(input string text, input bit [31:0] index, input bit restarts);
      req_type beat;
      for (int i = 0; i < text.len(); i++) begin
         beat.text_char = text[i];
         beat.start_req = (i == 0) || (restarts && $urandom_range(0, 99) == 0);
         beat.entry_index = beat.start_req ? ((i == 0) ? index : $urandom) : $urandom;
         send_beat(beat);
         chars_sent++;
      end
   endtask

   function automatic string any_char();
      return $sformatf("%c", 8'($urandom_range(1, 255)));
   endfunction

   function automatic string random_number();
      string s;
      int    n;
      s = ($urandom_range(0, 2) == 0) ? "-" : "";
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      if ($urandom_range(0, 3) != 0) begin
         s = {s, "."};
         repeat ($urandom_range(0, 8)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      end
      return s;
   endfunction

   function automatic string random_pair();
      string sep;
      string term;
      sep = ($urandom_range(0, 9) != 0) ? ";" : any_char();
      case ($urandom_range(0, 3))
         0: term = ",";
         1: term = ";";
         2: term = ".";
         default: term = any_char();
      endcase
      return {random_number(), sep, random_number(), term};
   endfunction

   initial begin : stimulus
      req_type noise;
      int      drain_cycles;
      converter = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      noise.text_char = "Z";
      noise.start_req = 1'b0;
      noise.entry_index = 32'd0;
      send_beat(noise);
      send_text("-.1234567;9..", 32'hFFFF_FFFF, 1'b0);
      send_text("5", 32'd1, 1'b0);
      send_text("5x", 32'd0, 1'b0);
      send_text("3000;;", 32'h1234_5678, 1'b0);

      while (chars_sent < CHAR_TARGET) begin
         if (chars_sent > 700 && chars_sent < 1000) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 23;
            rsp_idle_pct = 23;
         end
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               noise.text_char = 8'($urandom_range(0, 255));
               noise.start_req = ($urandom_range(0, 5) == 0);
               noise.entry_index = $urandom;
               send_beat(noise);
            end
         end
         send_text(random_pair(), $urandom, 1'b1);
      end
      req_valid <= 1'b0;

      drain_cycles = 0;
      while (converter.pending_points.size() != 0 && drain_cycles < 20000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (30) @(negedge clock);
      if (converter.pending_points.size() != 0) begin
         $error("%0d result beats never arrived", converter.pending_points.size());
         converter.bad_fields++;
      end
      if (converter.bad_fields == 0) begin
         $display("coordinate_text_to_grid_top: match");
      end else begin
         $display("coordinate_text_to_grid_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("coordinate_text_to_grid_top: mismatch");
      $finish;
   end

endmodule
